// File: src/fcsg_pkg.sv
// Shared types and constants for the filled circle span generator.
package fcsg_pkg;

    localparam int COORD_BITS = 10;
    localparam int RAD_BITS   = COORD_BITS - 1;
    localparam int DELTA_BITS = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 6;
    localparam int SPAN_BITS  = 12;
    localparam int COLOR_BITS = 8;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Midpoint loop state carried between iterations
    typedef struct packed {
        logic [COORD_BITS-1:0] ctr_x;
        logic [COORD_BITS-1:0] ctr_y;
        logic [COLOR_BITS-1:0] fill_color;
        logic [COORD_BITS-1:0] step_x;
        logic [COORD_BITS-1:0] step_y;
        logic [DELTA_BITS-1:0] x_delta;
        logic [DELTA_BITS-1:0] y_delta;
        logic [ERR_BITS-1:0]   err_acc;
    } circ_state_t;

    // What the span sequencer needs to emit the four spans of one iteration
    typedef struct packed {
        logic [COORD_BITS-1:0] ctr_x;
        logic [COORD_BITS-1:0] ctr_y;
        logic [COORD_BITS-1:0] step_x;
        logic [COORD_BITS-1:0] step_y;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
    } span_job_t;

endpackage

// File: src/filled_circle_span_generator.sv
// Filled circle span generator top level: loop state, span sequencer and result register.
//
// A start item (mode 0) latches centre, radius and colour and runs the first midpoint
// iteration; each advance item (mode 1) runs the next. Every iteration yields four
// horizontal spans, one per cycle on the result channel while it is not stalled by
// m_ready, so an item that produces spans holds off the next one; the next item is
// taken in the cycle the fourth span enters the result register. An advance with no
// circle in progress yields nothing. The fourth span of an iteration
// carries last_of_step, and that of the final iteration also circle_done. Spans are
// unclipped and wrap to 12-bit two's complement.
module filled_circle_span_generator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic [fcsg_pkg::COORD_BITS-1:0]       s_center_x,
    input  logic [fcsg_pkg::COORD_BITS-1:0]       s_center_y,
    input  logic [fcsg_pkg::RAD_BITS-1:0]         s_radius,
    input  logic [fcsg_pkg::COLOR_BITS-1:0]       s_color,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [fcsg_pkg::SPAN_BITS-1:0] m_span_row,
    output logic signed [fcsg_pkg::SPAN_BITS-1:0] m_span_left,
    output logic signed [fcsg_pkg::SPAN_BITS-1:0] m_span_right,
    output logic [fcsg_pkg::COLOR_BITS-1:0]       m_span_color,
    output logic                                  m_last_of_step,
    output logic                                  m_circle_done
);
    import fcsg_pkg::*;

    circ_state_t           state_reg;
    circ_state_t           state_next;
    logic                  busy_reg;
    span_job_t             job_reg;
    span_job_t             job_next;
    logic                  job_valid_reg;
    logic [1:0]            idx_reg;

    logic                  accept;
    logic                  is_start;
    logic                  runs;
    logic                  out_load;
    logic                  job_end;

    logic [SPAN_BITS-1:0]  cx;
    logic [SPAN_BITS-1:0]  cy;
    logic [SPAN_BITS-1:0]  sx;
    logic [SPAN_BITS-1:0]  sy;
    logic [SPAN_BITS-1:0]  row_sel;
    logic [SPAN_BITS-1:0]  left_sel;
    logic [SPAN_BITS-1:0]  right_sel;

    logic                  m_valid_reg;
    logic [SPAN_BITS-1:0]  row_reg;
    logic [SPAN_BITS-1:0]  left_reg;
    logic [SPAN_BITS-1:0]  right_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  last_reg;
    logic                  done_reg;

    fcsg_iter u_iter (
        .start     (is_start),
        .center_x  (s_center_x),
        .center_y  (s_center_y),
        .radius    (s_radius),
        .color     (s_color),
        .state_in  (state_reg),
        .state_out (state_next),
        .job       (job_next)
    );

    assign is_start = (s_mode == MODE_START);
    assign runs     = is_start || busy_reg;
    assign out_load = job_valid_reg && (!m_valid_reg || m_ready);
    assign job_end  = out_load && (idx_reg == 2'd3);
    assign s_ready  = !job_valid_reg || job_end;
    assign accept   = s_valid && s_ready;

    // Loop state and busy flag advance only on a transfer that runs an iteration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            busy_reg  <= 1'b0;
        end else if (accept && runs) begin
            state_reg <= state_next;
            busy_reg  <= !job_next.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (accept && runs) begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (job_end) begin
            job_valid_reg <= 1'b0;
        end else if (out_load) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && runs) begin
            job_reg <= job_next;
        end
    end

    always_comb begin
        cx = SPAN_BITS'(job_reg.ctr_x);
        cy = SPAN_BITS'(job_reg.ctr_y);
        sx = SPAN_BITS'(job_reg.step_x);
        sy = SPAN_BITS'(job_reg.step_y);
        case (idx_reg)
            2'd0: begin
                row_sel   = cy + sy;
                left_sel  = cx - sx;
                right_sel = cx + sx;
            end
            2'd1: begin
                row_sel   = cy - sy;
                left_sel  = cx - sx;
                right_sel = cx + sx;
            end
            2'd2: begin
                row_sel   = cy + sx;
                left_sel  = cx - sy;
                right_sel = cx + sy;
            end
            default: begin
                row_sel   = cy - sx;
                left_sel  = cx - sy;
                right_sel = cx + sy;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            row_reg   <= row_sel;
            left_reg  <= left_sel;
            right_reg <= right_sel;
            color_reg <= job_reg.color;
            last_reg  <= (idx_reg == 2'd3);
            done_reg  <= (idx_reg == 2'd3) && job_reg.done;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_span_row     = row_reg;
    assign m_span_left    = left_reg;
    assign m_span_right   = right_reg;
    assign m_span_color   = color_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = done_reg;

    // A completed circle is only ever flagged on the closing span of an iteration
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_circle_done |-> m_last_of_step)
        else $error("circle_done without last_of_step");

    // A start transfer always queues four spans
    a_start_queues: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_START) |=> job_valid_reg && (idx_reg == 2'd0))
        else $error("start transfer did not queue spans");

    // A pending final iteration means no circle is still active
    a_done_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg && job_reg.done |-> !busy_reg)
        else $error("busy still set after final iteration");

endmodule

// File: src/fcsg_iter.sv
// One midpoint circle iteration: start set-up, error update and end test.
module fcsg_iter (
    input  logic                                 start,
    input  logic [fcsg_pkg::COORD_BITS-1:0]      center_x,
    input  logic [fcsg_pkg::COORD_BITS-1:0]      center_y,
    input  logic [fcsg_pkg::RAD_BITS-1:0]        radius,
    input  logic [fcsg_pkg::COLOR_BITS-1:0]      color,
    input  fcsg_pkg::circ_state_t                state_in,
    output fcsg_pkg::circ_state_t                state_out,
    output fcsg_pkg::span_job_t                  job
);
    import fcsg_pkg::*;

    localparam int XB = COORD_BITS + 2;
    localparam int EW = ERR_BITS + 3;

    circ_state_t                 loaded;
    circ_state_t                 cur;
    logic signed [XB-1:0]        x_nxt;
    logic signed [XB-1:0]        y_nxt;
    logic signed [EW-1:0]        xd_ext;
    logic signed [EW-1:0]        e_mid;
    logic signed [EW-1:0]        e_nxt;
    logic signed [EW-1:0]        test;
    logic [DELTA_BITS-1:0]       xd_nxt;
    logic                        step_left;
    logic                        done;

    always_comb begin
        loaded.ctr_x      = center_x;
        loaded.ctr_y      = center_y;
        loaded.fill_color = color;
        loaded.step_x     = {1'b0, radius};
        loaded.step_y     = '0;
        loaded.x_delta    = DELTA_BITS'(1) - {2'b00, radius, 1'b0};
        loaded.y_delta    = '0;
        loaded.err_acc    = '0;
    end

    assign cur = start ? loaded : state_in;

    always_comb begin
        xd_ext    = {{(EW-DELTA_BITS){cur.x_delta[DELTA_BITS-1]}}, cur.x_delta};
        e_mid     = {{(EW-ERR_BITS){cur.err_acc[ERR_BITS-1]}}, cur.err_acc}
                  + {{(EW-DELTA_BITS){cur.y_delta[DELTA_BITS-1]}}, cur.y_delta};
        test      = (e_mid <<< 1) + xd_ext;
        step_left = (test > 0);
        y_nxt     = {2'b00, cur.step_y} + XB'(1);
        x_nxt     = {2'b00, cur.step_x};
        e_nxt     = e_mid;
        xd_nxt    = cur.x_delta;
        if (step_left) begin
            x_nxt  = x_nxt - XB'(1);
            e_nxt  = e_mid + xd_ext;
            xd_nxt = cur.x_delta + DELTA_BITS'(2);
        end
        done = (x_nxt < y_nxt);
    end

    always_comb begin
        state_out            = cur;
        state_out.step_x     = x_nxt[COORD_BITS-1:0];
        state_out.step_y     = y_nxt[COORD_BITS-1:0];
        state_out.x_delta    = xd_nxt;
        state_out.y_delta    = cur.y_delta + DELTA_BITS'(2);
        state_out.err_acc    = e_nxt[ERR_BITS-1:0];

        job.ctr_x  = cur.ctr_x;
        job.ctr_y  = cur.ctr_y;
        job.step_x = cur.step_x;
        job.step_y = cur.step_y;
        job.color  = cur.fill_color;
        job.done   = done;
    end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the filled circle span generator.
import fcsg_pkg::*;

typedef struct packed {
    logic [SPAN_BITS-1:0]  row;
    logic [SPAN_BITS-1:0]  left;
    logic [SPAN_BITS-1:0]  right;
    logic [COLOR_BITS-1:0] color;
    logic                  last_of_step;
    logic                  circle_done;
} span_t;

class span_scoreboard;
    logic [COORD_BITS-1:0] ctr_x, ctr_y, step_x, step_y;
    logic [COLOR_BITS-1:0] fill_color;
    logic [DELTA_BITS-1:0] x_delta, y_delta;
    logic [ERR_BITS-1:0]   err_acc;
    bit                    busy;
    span_t                 spans_due[$];
    int                    faults;

    function new();
        ctr_x = '0;
        ctr_y = '0;
        step_x = '0;
        step_y = '0;
        fill_color = '0;
        x_delta = '0;
        y_delta = '0;
        err_acc = '0;
        busy = 1'b0;
        faults = 0;
    endfunction

    function void queue_span(int row, int lo, int hi, logic last, logic fin);
        span_t s;
        s.row = row[SPAN_BITS-1:0];
        s.left = lo[SPAN_BITS-1:0];
        s.right = hi[SPAN_BITS-1:0];
        s.color = fill_color;
        s.last_of_step = last;
        s.circle_done = fin;
        spans_due.push_back(s);
    endfunction

    // One pass of the midpoint loop: spans use the values from before the step
    function void trace_iteration();
        int cx, cy, x, y, xd, yd, e, sx, sy;
        logic fin;
        cx = int'(ctr_x);
        cy = int'(ctr_y);
        sx = int'(step_x);
        sy = int'(step_y);
        x = sx;
        y = sy;
        xd = int'($signed(x_delta));
        yd = int'($signed(y_delta));
        e = int'($signed(err_acc));
        y = y + 1;
        e = e + yd;
        yd = yd + 2;
        if (e * 2 + xd > 0) begin
            x = x - 1;
            e = e + xd;
            xd = xd + 2;
        end
        fin = (x < y);
        queue_span(cy + sy, cx - sx, cx + sx, 1'b0, 1'b0);
        queue_span(cy - sy, cx - sx, cx + sx, 1'b0, 1'b0);
        queue_span(cy + sx, cx - sy, cx + sy, 1'b0, 1'b0);
        queue_span(cy - sx, cx - sy, cx + sy, 1'b1, fin);
        step_x = x[COORD_BITS-1:0];
        step_y = y[COORD_BITS-1:0];
        x_delta = xd[DELTA_BITS-1:0];
        y_delta = yd[DELTA_BITS-1:0];
        err_acc = e[ERR_BITS-1:0];
        busy = !fin;
    endfunction

    function void note_command(logic mode, logic [COORD_BITS-1:0] cx,
                               logic [COORD_BITS-1:0] cy, logic [RAD_BITS-1:0] r,
                               logic [COLOR_BITS-1:0] col);
        int d;
        if (mode == MODE_START) begin
            d = 1 - 2 * int'(r);
            ctr_x = cx;
            ctr_y = cy;
            fill_color = col;
            step_x = {1'b0, r};
            step_y = '0;
            x_delta = d[DELTA_BITS-1:0];
            y_delta = '0;
            err_acc = '0;
            busy = 1'b1;
        end
        if (mode == MODE_START || busy)
            trace_iteration();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            faults++;
        end
    endfunction

    function void check_span(span_t got);
        span_t want;
        if (spans_due.size() == 0) begin
            $display("%0t: unexpected span, got %h", $time, got);
            faults++;
            return;
        end
        want = spans_due.pop_front();
        compare_field("span_row", 16'(want.row), 16'(got.row));
        compare_field("span_left", 16'(want.left), 16'(got.left));
        compare_field("span_right", 16'(want.right), 16'(got.right));
        compare_field("span_color", 16'(want.color), 16'(got.color));
        compare_field("last_of_step", 16'(want.last_of_step), 16'(got.last_of_step));
        compare_field("circle_done", 16'(want.circle_done), 16'(got.circle_done));
    endfunction
endclass

module testbench;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_mode = MODE_ADVANCE;
    logic [COORD_BITS-1:0]        s_center_x = '0;
    logic [COORD_BITS-1:0]        s_center_y = '0;
    logic [RAD_BITS-1:0]          s_radius = '0;
    logic [COLOR_BITS-1:0]        s_color = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [SPAN_BITS-1:0]  m_span_row;
    logic signed [SPAN_BITS-1:0]  m_span_left;
    logic signed [SPAN_BITS-1:0]  m_span_right;
    logic [COLOR_BITS-1:0]        m_span_color;
    logic                         m_last_of_step;
    logic                         m_circle_done;

    span_scoreboard sb;
    int items_sent = 0;
    int spans_seen = 0;
    int quiet_cycles = 0;

    filled_circle_span_generator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_radius       (s_radius),
        .s_color        (s_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_span_row     (m_span_row),
        .m_span_left    (m_span_left),
        .m_span_right   (m_span_right),
        .m_span_color   (m_span_color),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return 0;
        else if (k < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_command(input logic mode, input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [RAD_BITS-1:0] r,
                                input logic [COLOR_BITS-1:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius <= r;
        s_color <= col;
        forever begin
            @(posedge aclk);
            if (s_ready === 1'b1)
                break;
        end
        sb.note_command(mode, cx, cy, r, col);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_advance();
        send_command(MODE_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     RAD_BITS'($urandom), COLOR_BITS'($urandom));
    endtask

    initial begin : stimulus
        int r;
        int steps;
        int pick;
        bit wide;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // advance with nothing running, then a zero radius circle
        send_command(MODE_ADVANCE, '1, '1, '1, '1);
        send_command(MODE_START, '0, '0, '0, '0);
        send_command(MODE_ADVANCE, '0, '0, '0, '0);
        // largest centre and radius, cut short by a fresh start
        send_command(MODE_START, '1, '1, '1, '1);
        repeat (3) send_command(MODE_ADVANCE, '1, '1, '1, '1);
        send_command(MODE_START, '0, '0, 9'd3, 8'hA5);
        repeat (4) send_command(MODE_ADVANCE, '0, '0, '0, '0);
        send_command(MODE_START, 10'd512, 10'd0, 9'd1, 8'h5A);
        repeat (2) send_command(MODE_ADVANCE, 10'h155, 10'h2AA, 9'h0AA, 8'h33);

        while (items_sent < 260) begin
            if ($urandom_range(0, 9) == 0) begin
                send_advance();
            end else begin
                pick = $urandom_range(0, 15);
                wide = (pick == 0);
                if (wide)
                    r = $urandom_range(41, 511);
                else if (pick < 5)
                    r = $urandom_range(13, 40);
                else
                    r = $urandom_range(0, 12);
                send_command(MODE_START, COORD_BITS'($urandom_range(0, 1023)),
                             COORD_BITS'($urandom_range(0, 1023)),
                             r[RAD_BITS-1:0], COLOR_BITS'($urandom_range(0, 255)));
                // large circles are dropped early by the next start
                steps = wide ? $urandom_range(1, 6) : 1000;
                while (sb.busy && steps > 0 && $urandom_range(0, 39) != 0) begin
                    send_advance();
                    steps--;
                end
            end
        end
        s_valid <= 1'b0;

        while (sb.spans_due.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : span_sink
        int run;
        int gap;
        bit held_off;
        held_off = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat (run - 1) @(negedge aclk);
            gap = pick_gap();
            // one long hold-off so the block fills and stalls its input
            if (!held_off && spans_seen >= 80) begin
                gap = HOLD_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            sb.check_span({m_span_row, m_span_left, m_span_right, m_span_color,
                           m_last_of_step, m_circle_done});
            spans_seen++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready === 1'b1)
                || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end
endmodule
